>>> rtl/core/tbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Types, codes and sizes shared by the token bucket packet shaper files.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int TBS_QUEUE_DEPTH = 64;
    localparam int ID_W            = 16;
    localparam int TOKEN_W         = 10;
    localparam int TOTAL_W         = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [TOKEN_W-1:0] DEPTH_RESET = TOKEN_W'(10);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_DEPTH = 1'b0,
        CFG_PACKET_TOTAL = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_ARRIVAL = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        TOK_NONE    = 2'd0,
        TOK_ADDED   = 2'd1,
        TOK_DROPPED = 2'd2
    } token_event_t;

    typedef enum logic [2:0] {
        PKT_NONE      = 3'd0,
        PKT_QUEUED    = 3'd1,
        PKT_TOO_LARGE = 3'd2,
        PKT_FULL      = 3'd3,
        PKT_PAST      = 3'd4
    } packet_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TOKEN_W-1:0] need;
    } slot_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic resolve;
    } dp_cmd_t;

    typedef struct packed {
        logic check;
    } dp_status_t;

endpackage

>>> rtl/core/tbs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_in_if
// Input item channel: token ticks and packet arrivals.
// ----------------------------------------------------------------------------
interface tbs_in_if
    import tbs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [ID_W-1:0]    packet_id;
    logic [TOKEN_W-1:0] tokens_needed;

    modport source (output valid, output opcode, output packet_id, output tokens_needed,
                    input ready);
    modport sink   (input valid, input opcode, input packet_id, input tokens_needed,
                    output ready);
endinterface

>>> rtl/core/tbs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_out_if
// Result channel: one result beat per input item.
// ----------------------------------------------------------------------------
interface tbs_out_if
    import tbs_pkg::*;
#(
    parameter int COUNT_W = 7
);
    logic               valid;
    logic               ready;
    logic [1:0]         token_event;
    logic [2:0]         packet_event;
    logic               released;
    logic [ID_W-1:0]    released_id;
    logic [TOKEN_W-1:0] token_level;
    logic [COUNT_W-1:0] queue_length;

    modport source (output valid, output token_event, output packet_event, output released,
                    output released_id, output token_level, output queue_length,
                    input ready);
    modport sink   (input valid, input token_event, input packet_event, input released,
                    input released_id, input token_level, input queue_length,
                    output ready);
endinterface

>>> rtl/core/tbs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tbs_cfg_if
    import tbs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/tbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_ctrl
// Sequencer for the shaper: capture, execute, fetch head, resolve release.
// ----------------------------------------------------------------------------
module tbs_ctrl
    import tbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // skip the head fetch when no release check is due
                state_next = status.check ? ST_FETCH : ST_RESOLVE;
            end
            ST_FETCH:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.resolve = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            ST_FETCH:
            begin
            end
            ST_RESOLVE:
            begin
                cmd.resolve = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cmd.resolve)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/tbs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_datapath
// Bucket, arrival counter, packet FIFO and result register of the shaper.
// ----------------------------------------------------------------------------
module tbs_datapath
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = TBS_QUEUE_DEPTH,
    parameter int COUNT_W     = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  opcode,
    input  logic [ID_W-1:0]       packet_id,
    input  logic [TOKEN_W-1:0]    tokens_needed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [1:0]            token_event,
    output logic [2:0]            packet_event,
    output logic                  released,
    output logic [ID_W-1:0]       released_id,
    output logic [TOKEN_W-1:0]    token_level,
    output logic [COUNT_W-1:0]    queue_length
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(QUEUE_DEPTH);

    // configuration
    logic [TOKEN_W-1:0] depth_reg;
    logic [TOTAL_W-1:0] total_reg;

    // architectural state
    logic [TOKEN_W-1:0] token_reg, token_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] arrivals_reg, arrivals_next;

    // captured item and execute results
    logic               op_reg;
    logic [ID_W-1:0]    pid_reg;
    logic [TOKEN_W-1:0] need_reg;
    token_event_t       tev_reg, tev_next;
    packet_event_t      pev_reg, pev_next;
    logic               check_reg, check_next;
    logic               push;

    // FIFO storage
    slot_t              mem [QUEUE_DEPTH];
    slot_t              head_slot_reg;

    // result register
    logic [1:0]         res_tev_reg;
    logic [2:0]         res_pev_reg;
    logic               res_rel_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [TOKEN_W-1:0] res_level_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               live;
    logic               release_ok;

    assign live = arrivals_reg < total_reg;

    // execute step: bucket and arrival side
    always_comb
    begin
        tev_next      = TOK_NONE;
        pev_next      = PKT_NONE;
        check_next    = 1'b0;
        push          = 1'b0;
        arrivals_next = arrivals_reg;
        if (op_reg == OP_TICK)
        begin
            if (live)
            begin
                if (token_reg < depth_reg)
                begin
                    tev_next   = TOK_ADDED;
                    check_next = 1'b1;
                end
                else
                begin
                    tev_next = TOK_DROPPED;
                end
            end
        end
        else
        begin
            if (!live)
            begin
                pev_next = PKT_PAST;
            end
            else
            begin
                arrivals_next = arrivals_reg + TOTAL_W'(1);
                if (need_reg > depth_reg)
                    pev_next = PKT_TOO_LARGE;
                else if (count_reg >= FULL_CNT)
                    pev_next = PKT_FULL;
                else
                begin
                    pev_next   = PKT_QUEUED;
                    check_next = 1'b1;
                    push       = 1'b1;
                end
            end
        end
    end

    assign status.check = check_next;

    assign release_ok = check_reg && (count_reg != '0) && (token_reg >= head_slot_reg.need);

    // state update: execute adds a token or pushes, resolve pops
    always_comb
    begin
        token_next = token_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.execute)
        begin
            if (tev_next == TOK_ADDED)
                token_next = token_reg + TOKEN_W'(1);
            if (push)
            begin
                tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                count_next = count_reg + COUNT_W'(1);
            end
        end
        else if (cmd.resolve && release_ok)
        begin
            token_next = token_reg - head_slot_reg.need;
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= DEPTH_RESET;
            total_reg    <= TOTAL_RESET;
            token_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            arrivals_reg <= '0;
            check_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_BUCKET_DEPTH: depth_reg <= cfg_data[TOKEN_W-1:0];
                    CFG_PACKET_TOTAL: total_reg <= cfg_data[TOTAL_W-1:0];
                    default:          ;
                endcase
            end
            token_reg <= token_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.execute)
            begin
                arrivals_reg <= arrivals_next;
                check_reg    <= check_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            pid_reg  <= packet_id;
            need_reg <= tokens_needed;
        end
        if (cmd.execute)
        begin
            tev_reg <= tev_next;
            pev_reg <= pev_next;
        end
        if (cmd.resolve)
        begin
            res_tev_reg   <= tev_reg;
            res_pev_reg   <= pev_reg;
            res_rel_reg   <= release_ok;
            res_id_reg    <= release_ok ? head_slot_reg.id : '0;
            res_level_reg <= token_next;
            res_count_reg <= count_next;
        end
    end

    // FIFO memory: one write port, registered read of the head slot
    always_ff @(posedge clk)
    begin
        if (cmd.execute && push)
            mem[tail_reg] <= '{id: pid_reg, need: need_reg};
        head_slot_reg <= mem[head_reg];
    end

    assign token_event  = res_tev_reg;
    assign packet_event = res_pev_reg;
    assign released     = res_rel_reg;
    assign released_id  = res_id_reg;
    assign token_level  = res_level_reg;
    assign queue_length = res_count_reg;

endmodule

>>> rtl/core/token_bucket_packet_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper
// Token bucket in front of a packet FIFO; one result beat per tick or arrival.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+----------------------------------------------
//   item    | in  | valid / ready | opcode, packet_id, tokens_needed
//   result  | out | valid / ready | token_event, packet_event, released,
//           |     |               | released_id, token_level, queue_length
//   cfg     | in  | valid / ready | index, data (ready is always high)
//
// An item passes the capture, execute and resolve states, plus a head fetch state
// for the registered read of the head slot when a release check is due.
// The next item is taken while a result beat still waits on the result side;
// a stalled result only holds the block once the next result is ready.
// Reset clears bucket, pointers and counters and loads the configuration
// defaults; FIFO slots are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
module token_bucket_packet_shaper
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = TBS_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    tbs_in_if.sink         item,
    tbs_out_if.source      result,
    tbs_cfg_if.sink        cfg
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    tbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tbs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_W     (COUNT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (item.opcode),
        .packet_id     (item.packet_id),
        .tokens_needed (item.tokens_needed),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .token_event   (result.token_event),
        .packet_event  (result.packet_event),
        .released      (result.released),
        .released_id   (result.released_id),
        .token_level   (result.token_level),
        .queue_length  (result.queue_length)
    );

endmodule

>>> rtl/core/tbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks on the shaper, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker
    import tbs_pkg::*;
#(
    parameter int COUNT_W = 7
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         token_event,
    input logic [2:0]         packet_event,
    input logic               released,
    input logic [ID_W-1:0]    released_id,
    input logic [TOKEN_W-1:0] token_level,
    input logic [COUNT_W-1:0] queue_length
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(released_id) && $stable(token_level)
            && $stable(queue_length) && $stable(token_event) && $stable(packet_event))
        else $error("result payload changed while stalled");

    // one item at a time: ready drops right after an accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in flight");

    // no release means a zero id
    a_rel_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !released |-> released_id == '0)
        else $error("released_id set without release");

    // a beat reports a token event or a packet event, never both
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_event != TOK_NONE |-> packet_event == PKT_NONE)
        else $error("token and packet event in one beat");

endmodule

bind token_bucket_packet_shaper tbs_checker #(
    .COUNT_W (COUNT_W)
) u_tbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .token_event  (result.token_event),
    .packet_event (result.packet_event),
    .released     (result.released),
    .released_id  (result.released_id),
    .token_level  (result.token_level),
    .queue_length (result.queue_length)
);

>>> dv/tb_token_bucket_packet_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_bucket_packet_shaper
// Self-checking bench for the token bucket packet shaper. A bit-accurate
// shaper model runs on every accepted tick or arrival and queues the result
// beat it predicts. Each result beat is compared with the oldest prediction.
// Directed tests cover the reset settings, zero depth, a lowered depth, the
// arrival total and a full queue. Random traffic runs under three patterns
// of sender and receiver stalls, with the full queue test after the first.
// ----------------------------------------------------------------------------
module tb_token_bucket_packet_shaper
    import tbs_pkg::*;
;

    localparam int QDEPTH      = TBS_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        token_event_t       tev;
        packet_event_t      pev;
        logic               rel;
        logic [ID_W-1:0]    rid;
        logic [TOKEN_W-1:0] level;
        logic [6:0]         qlen;
    } shaper_beat_t;

    logic clk;
    logic rst_n;

    tbs_in_if              item ();
    tbs_out_if #(.COUNT_W(7)) result ();
    tbs_cfg_if             cfg ();

    token_bucket_packet_shaper #(.QUEUE_DEPTH(QDEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // Shaper model state and settings
    logic [TOKEN_W-1:0] depth_cfg;
    logic [TOTAL_W-1:0] total_cfg;
    logic [TOKEN_W-1:0] bucket_level;
    logic [ID_W-1:0]    fifo_id   [QDEPTH];
    logic [TOKEN_W-1:0] fifo_need [QDEPTH];
    int                 fifo_head;
    int                 fifo_tail;
    int                 fifo_count;
    int                 arrivals;

    shaper_beat_t expected_beats[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           in_idle_pct;
    int           out_idle_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic shaper_beat_t shape_item(input opcode_t op,
                                                input logic [ID_W-1:0] pid,
                                                input logic [TOKEN_W-1:0] need);
        shaper_beat_t b;
        logic         check;
        b     = '0;
        check = 1'b0;
        if (op == OP_TICK)
        begin
            // drop ticks silently once the arrival total is reached
            if (arrivals < total_cfg)
            begin
                if (bucket_level < depth_cfg)
                begin
                    bucket_level = bucket_level + 1'b1;
                    b.tev        = TOK_ADDED;
                    check        = 1'b1;
                end
                else
                begin
                    b.tev = TOK_DROPPED;
                end
            end
        end
        else if (arrivals >= total_cfg)
        begin
            b.pev = PKT_PAST;
        end
        else
        begin
            arrivals++;
            if (need > depth_cfg)
            begin
                b.pev = PKT_TOO_LARGE;
            end
            else if (fifo_count >= QDEPTH)
            begin
                b.pev = PKT_FULL;
            end
            else
            begin
                fifo_id[fifo_tail]   = pid;
                fifo_need[fifo_tail] = need;
                fifo_tail            = (fifo_tail + 1) % QDEPTH;
                fifo_count++;
                b.pev = PKT_QUEUED;
                check = 1'b1;
            end
        end
        if (check && fifo_count != 0 && bucket_level >= fifo_need[fifo_head])
        begin
            bucket_level = bucket_level - fifo_need[fifo_head];
            b.rel        = 1'b1;
            b.rid        = fifo_id[fifo_head];
            fifo_head    = (fifo_head + 1) % QDEPTH;
            fifo_count--;
        end
        b.level = bucket_level;
        b.qlen  = 7'(fifo_count);
        return b;
    endfunction

    always @(posedge clk)
    begin : result_check
        shaper_beat_t got;
        shaper_beat_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got.tev   = token_event_t'(result.token_event);
            got.pev   = packet_event_t'(result.packet_event);
            got.rel   = result.released;
            got.rid   = result.released_id;
            got.level = result.token_level;
            got.qlen  = result.queue_length;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at cycle %0d", cycle_count);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d: exp tev=%0d pev=%0d rel=%0b rid=%h lvl=%0d qlen=%0d",
                                 cycle_count, want.tev, want.pev, want.rel, want.rid,
                                 want.level, want.qlen);
                        $display("    got tev=%0d pev=%0d rel=%0b rid=%h lvl=%0d qlen=%0d",
                                 got.tev, got.pev, got.rel, got.rid, got.level, got.qlen);
                    end
                end
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [ID_W-1:0] pid,
                             input logic [TOKEN_W-1:0] need);
        while ($urandom_range(99) < in_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid         <= 1'b1;
        item.opcode        <= op;
        item.packet_id     <= pid;
        item.tokens_needed <= need;
        do @(posedge clk); while (!item.ready);
        expected_beats.push_back(shape_item(op, pid, need));
    endtask

    // Hold the sender until every predicted beat has come back
    task automatic drain_results();
        item.valid <= 1'b0;
        do @(posedge clk); while (expected_beats.size() != 0);
    endtask

    task automatic set_config(input logic [TOKEN_W-1:0] depth,
                              input logic [TOTAL_W-1:0] total);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.index <= CFG_BUCKET_DEPTH;
        cfg.data  <= {6'($urandom), depth};
        do @(posedge clk); while (!cfg.ready);
        depth_cfg = depth;
        cfg.index <= CFG_PACKET_TOTAL;
        cfg.data  <= total;
        do @(posedge clk); while (!cfg.ready);
        total_cfg = total;
        cfg.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(OP_TICK, 16'hFFFF, 10'h3FF);
        send_item(OP_TICK, 16'h0000, 10'h000);
        send_item(OP_ARRIVAL, 16'hFFFF, 10'd0);
        send_item(OP_ARRIVAL, 16'h0000, 10'd3);
        send_item(OP_TICK, 16'h5A5A, 10'h155);
        send_item(OP_ARRIVAL, 16'hA5A5, 10'h3FF);
    endtask

    task automatic test_zero_depth();
        set_config(10'd0, 16'hFFFF);
        send_item(OP_TICK, 16'h1234, 10'd1);
        send_item(OP_ARRIVAL, 16'h1234, 10'd0);
        send_item(OP_ARRIVAL, 16'h4321, 10'd1);
    endtask

    task automatic test_depth_lowered();
        set_config(10'd4, 16'hFFFF);
        repeat (5) send_item(OP_TICK, ID_W'($urandom), TOKEN_W'($urandom));
        set_config(10'd1, 16'hFFFF);
        send_item(OP_TICK, ID_W'($urandom), TOKEN_W'($urandom));
    endtask

    task automatic test_past_total();
        set_config(10'd1023, 16'd0);
        send_item(OP_TICK, 16'hFFFF, 10'h3FF);
        send_item(OP_ARRIVAL, 16'hFFFF, 10'h3FF);
        set_config(10'd1023, TOTAL_W'(arrivals + 1));
        send_item(OP_ARRIVAL, 16'hBEEF, 10'd0);
        send_item(OP_ARRIVAL, 16'hCAFE, 10'd0);
        send_item(OP_TICK, 16'h0001, 10'd1);
    endtask

    task automatic test_queue_full();
        int extra;
        int guard;
        extra = 0;
        guard = 0;
        set_config(10'd8, 16'hFFFF);
        // block the head, then pile up one-token packets behind it
        send_item(OP_ARRIVAL, ID_W'($urandom), 10'd8);
        while ((fifo_count < QDEPTH || extra < 3) && guard < 1200)
        begin
            if (fifo_count >= QDEPTH)
                extra++;
            send_item(OP_ARRIVAL, ID_W'($urandom), 10'd1);
            guard++;
        end
        guard = 0;
        while (fifo_count > 0 && guard < 200)
        begin
            send_item(OP_TICK, ID_W'($urandom), TOKEN_W'($urandom));
            guard++;
        end
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items);
        int                 sent;
        int                 seg_len;
        int                 pick;
        int                 cap;
        logic [TOKEN_W-1:0] depth;
        logic [TOKEN_W-1:0] need;
        logic [ID_W-1:0]    pid;
        opcode_t            op;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(1) == 0 || sent == 0)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0:       depth = 10'd1;
                    1:       depth = 10'd1023;
                    2:       depth = 10'd0;
                    3, 4, 5: depth = TOKEN_W'($urandom_range(1, 16));
                    default: depth = TOKEN_W'($urandom_range(1, 1023));
                endcase
                if ($urandom_range(7) == 0)
                    set_config(depth, TOTAL_W'(arrivals + $urandom_range(0, 4)));
                else
                    set_config(depth, 16'hFFFF);
            end
            seg_len = $urandom_range(20, 60);
            cap = (depth_cfg < 40) ? int'(depth_cfg) : 40;
            repeat (seg_len)
            begin
                op   = ($urandom_range(99) < 55) ? OP_TICK : OP_ARRIVAL;
                pick = $urandom_range(99);
                case ($urandom_range(9))
                    0:       pid = 16'h0000;
                    1:       pid = 16'hFFFF;
                    default: pid = ID_W'($urandom);
                endcase
                if (pick < 75)
                    need = TOKEN_W'($urandom_range(0, (cap < 6) ? cap : 6));
                else if (pick < 90 || depth_cfg == 10'd1023)
                    need = TOKEN_W'($urandom_range(0, cap));
                else
                    need = TOKEN_W'($urandom_range(int'(depth_cfg) + 1, 1023));
                send_item(op, pid, need);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        item.valid         <= 1'b0;
        item.opcode        <= OP_TICK;
        item.packet_id     <= '0;
        item.tokens_needed <= '0;
        cfg.valid          <= 1'b0;
        cfg.index          <= CFG_BUCKET_DEPTH;
        cfg.data           <= '0;
        in_idle_pct  = 24;
        out_idle_pct = 52;
        depth_cfg    = DEPTH_RESET;
        total_cfg    = TOTAL_RESET;
        bucket_level = '0;
        fifo_head    = 0;
        fifo_tail    = 0;
        fifo_count   = 0;
        arrivals     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_depth();
        test_depth_lowered();
        test_past_total();
        test_random_traffic(24, 52, 370);
        test_queue_full();
        test_random_traffic(52, 24, 370);
        test_random_traffic(0, 0, 370);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tbs_pkg.sv
rtl/core/tbs_in_if.sv
rtl/core/tbs_out_if.sv
rtl/core/tbs_cfg_if.sv
rtl/core/tbs_ctrl.sv
rtl/core/tbs_datapath.sv
rtl/core/token_bucket_packet_shaper.sv
rtl/core/tbs_checker.sv
dv/tb_token_bucket_packet_shaper.sv
